### hdl/first_fit_page_allocator_core_defines.svh
// ============================================================================
// first_fit_page_allocator_core_defines.svh
// Assertion macros for the first-fit page allocator.
// ============================================================================
`ifndef FIRST_FIT_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH

// Check a property on aclk, masked while aresetn is low
`define FFPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check a property on aclk, also during reset
`define FFPA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`else

`define FFPA_ASSERT(label, prop, msg)
`define FFPA_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### hdl/ffpa_pkg.sv
// ============================================================================
// ffpa_pkg
// Shared widths, codes and defaults of the first-fit page allocator.
// ============================================================================
package ffpa_pkg;

    // Field widths
    localparam int ADDR_W    = 48;
    localparam int BYTES_W   = 32;
    localparam int SHIFT_W   = 5;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 3;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W  = 2;

    // Defaults and limits
    localparam int PAGE_DEPTH_DEFAULT = 1024;
    localparam int SHIFT_MIN = 12;
    localparam int SHIFT_MAX = 20;
    // Widest page count that a byte request can round up to
    localparam int NEED_W = BYTES_W - SHIFT_MIN + 1;

    localparam logic [ADDR_W-1:0]  HEAP_BASE_RESET  = '0;
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = SHIFT_W'(12);
    localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET = COUNT_W'(1024);

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_HOLE   = 3'd1,
        ST_NULL      = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOT_START = 3'd4
    } status_t;

endpackage

### hdl/ffpa_ram.sv
// ============================================================================
// ffpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module ffpa_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write and read; read data is registered
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/first_fit_page_allocator_core.sv
// Flow: an allocate decodes, scans the table for a free run and marks the granted pages;
//   a free range-checks, checks alignment and releases the block page by page; early rejects skip ahead.
// Throughput: one item at a time, the next word taken once the result loads;
//   the page table RAM walks one page per cycle.
// Reset: synchronous on aresetn low; a clearing pass then empties the
//   table, and no item is taken until it ends (configuration writes are taken throughout).
// ============================================================================
// first_fit_page_allocator_core
// First-fit contiguous page allocator over a page table RAM holding a used mark
// and owner page index per entry.
// ============================================================================
`include "first_fit_page_allocator_core_defines.svh"

module first_fit_page_allocator_core #(
    parameter int PAGE_DEPTH = ffpa_pkg::PAGE_DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input word
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] operation, [32:1] request_bytes, [80:33] free_address, [87:81] zero
    input  logic [ffpa_pkg::IN_DATA_W-1:0]     s_tdata,
    // Result word
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] status, [50:3] block_address, [55:51] zero
    output logic [ffpa_pkg::OUT_DATA_W-1:0]    m_tdata,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffpa_pkg::ADDR_W-1:0]        cfg_data
);

    import ffpa_pkg::*;

    localparam int IDX_W = $clog2(PAGE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int ENT_W = IDX_W + 1;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DECODE = 9'b000000100,
        S_ASCAN  = 9'b000001000,
        S_AWRITE = 9'b000010000,
        S_FALIGN = 9'b000100000,
        S_FSTART = 9'b001000000,
        S_FWALK  = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ADDR_W:0]    top_reg, top_next;
    logic [SHIFT_W-1:0] eff_shift;
    logic [CNT_W-1:0]   eff_count;

    // Captured item
    logic               op_reg, op_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [ADDR_W-1:0]  faddr_reg, faddr_next;

    // Walk state
    logic [NEED_W-1:0]  need_reg, need_next;
    logic [NEED_W-1:0]  need_calc;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]   run_inc;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]   start_cand;
    logic [IDX_W-1:0]   end_reg, end_next;
    logic [ADDR_W-1:0]  off_reg, off_next;
    logic [IDX_W-1:0]   off_idx;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]   idx_inc;
    logic               at_last;

    // Pending result and output register
    status_t            res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [ADDR_W-1:0]  alloc_addr;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [ADDR_W-1:0]  m_addr_reg, m_addr_next;

    // Page table port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;
    logic               rd_used;
    logic [IDX_W-1:0]   rd_owner;

    ffpa_ram #(
        .DATA_W (ENT_W),
        .DEPTH  (PAGE_DEPTH)
    ) u_page_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_used  = ram_rdata[IDX_W];
    assign rd_owner = ram_rdata[IDX_W-1:0];

    // Clamp the page size and page count
    always_comb begin
        if (shift_reg < SHIFT_W'(SHIFT_MIN)) begin
            eff_shift = SHIFT_W'(SHIFT_MIN);
        end else if (shift_reg > SHIFT_W'(SHIFT_MAX)) begin
            eff_shift = SHIFT_W'(SHIFT_MAX);
        end else begin
            eff_shift = shift_reg;
        end
        if (32'(count_reg) > 32'(PAGE_DEPTH)) begin
            eff_count = CNT_W'(PAGE_DEPTH);
        end else begin
            eff_count = CNT_W'(count_reg);
        end
    end

    // Exclusive upper bound of the heap, refreshed every cycle
    assign top_next = {1'b0, base_reg} + ((ADDR_W + 1)'(eff_count) << eff_shift);

    // Round the request up to whole pages
    assign need_calc = NEED_W'(bytes_reg >> eff_shift)
                     + NEED_W'(|(bytes_reg & ((BYTES_W'(1) << eff_shift) - BYTES_W'(1))));

    assign off_idx    = IDX_W'(off_reg >> eff_shift);
    assign idx_inc    = {1'b0, idx_reg} + CNT_W'(1);
    assign at_last    = (idx_inc >= eff_count);
    assign run_inc    = run_reg + CNT_W'(1);
    assign start_cand = (run_reg == '0) ? idx_reg : start_reg;
    assign alloc_addr = base_reg + (ADDR_W'(start_reg) << eff_shift);

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_comb begin
        base_next  = base_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_HEAP_BASE:  base_next  = cfg_data;
                CFG_PAGE_SHIFT: shift_next = cfg_data[SHIFT_W-1:0];
                CFG_PAGE_COUNT: count_next = cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        bytes_next      = bytes_reg;
        faddr_next      = faddr_reg;
        need_next       = need_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        off_next        = off_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;
        ram_raddr       = idx_reg;

        // Drop the result word once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            // Sweep the page table to empty
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(PAGE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            // Capture the input word
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[0];
                    bytes_next = s_tdata[BYTES_W:1];
                    faddr_next = s_tdata[BYTES_W+ADDR_W:BYTES_W+1];
                    state_next = S_DECODE;
                end
            end
            // Size an allocate, range-check a free
            S_DECODE: begin
                res_addr_next = '0;
                if (op_reg == OP_ALLOC) begin
                    need_next = need_calc;
                    if (need_calc == '0 || eff_count == '0) begin
                        res_status_next = ST_NO_HOLE;
                        state_next      = S_DONE;
                    end else begin
                        ram_raddr  = '0;
                        idx_next   = '0;
                        run_next   = '0;
                        state_next = S_ASCAN;
                    end
                end else if (faddr_reg == '0) begin
                    res_status_next = ST_NULL;
                    state_next      = S_DONE;
                end else if (faddr_reg < base_reg || {1'b0, faddr_reg} >= top_reg) begin
                    res_status_next = ST_RANGE;
                    state_next      = S_DONE;
                end else begin
                    off_next   = faddr_reg - base_reg;
                    state_next = S_FALIGN;
                end
            end
            // Look for a free run of need_reg pages
            S_ASCAN: begin
                if (!rd_used && (32'(run_inc) == 32'(need_reg))) begin
                    start_next = start_cand;
                    end_next   = idx_reg;
                    idx_next   = start_cand;
                    state_next = S_AWRITE;
                end else begin
                    if (!rd_used) begin
                        start_next = start_cand;
                        run_next   = run_inc;
                    end else begin
                        run_next = '0;
                    end
                    if (at_last) begin
                        res_status_next = ST_NO_HOLE;
                        state_next      = S_DONE;
                    end else begin
                        idx_next  = IDX_W'(idx_inc);
                        ram_raddr = IDX_W'(idx_inc);
                    end
                end
            end
            // Mark the run used, owned by its first page
            S_AWRITE: begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, start_reg};
                if (idx_reg == end_reg) begin
                    res_status_next = ST_OK;
                    res_addr_next   = alloc_addr;
                    state_next      = S_DONE;
                end else begin
                    idx_next = IDX_W'(idx_inc);
                end
            end
            // Check page alignment, fetch the start entry
            S_FALIGN: begin
                if ((off_reg & ((ADDR_W'(1) << eff_shift) - ADDR_W'(1))) != '0) begin
                    res_status_next = ST_NOT_START;
                    state_next      = S_DONE;
                end else begin
                    idx_next   = off_idx;
                    start_next = off_idx;
                    ram_raddr  = off_idx;
                    state_next = S_FSTART;
                end
            end
            // Release the start page if it heads a live block
            S_FSTART: begin
                if (!rd_used || rd_owner != idx_reg) begin
                    res_status_next = ST_NOT_START;
                    state_next      = S_DONE;
                end else begin
                    ram_we          = 1'b1;
                    res_status_next = ST_OK;
                    if (at_last) begin
                        state_next = S_DONE;
                    end else begin
                        idx_next   = IDX_W'(idx_inc);
                        ram_raddr  = IDX_W'(idx_inc);
                        state_next = S_FWALK;
                    end
                end
            end
            // Release following pages of the same block; reads run one entry ahead of writes
            S_FWALK: begin
                if (rd_used && rd_owner == start_reg) begin
                    ram_we = 1'b1;
                    if (at_last) begin
                        state_next = S_DONE;
                    end else begin
                        idx_next  = IDX_W'(idx_inc);
                        ram_raddr = IDX_W'(idx_inc);
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            // Hand the result to the output register
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            base_reg    <= HEAP_BASE_RESET;
            shift_reg   <= PAGE_SHIFT_RESET;
            count_reg   <= PAGE_COUNT_RESET;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            base_reg    <= base_next;
            shift_reg   <= shift_next;
            count_reg   <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        top_reg        <= top_next;
        op_reg         <= op_next;
        bytes_reg      <= bytes_next;
        faddr_reg      <= faddr_next;
        need_reg       <= need_next;
        idx_reg        <= idx_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        off_reg        <= off_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - ADDR_W - STATUS_W)'(0), m_addr_reg, m_status_reg};

    // Checks
    `FFPA_ASSERT(a_accept_decodes, (s_tvalid && s_tready) |=> (state_reg == S_DECODE), "no decode")
    `FFPA_ASSERT(a_fail_no_addr, (m_tvalid && (m_status_reg != ST_OK)) |-> (m_addr_reg == '0), "fail addr")
    `FFPA_ASSERT_ALWAYS(a_scan_read_only, (state_reg == S_ASCAN) |-> !ram_we, "write during scan")

endmodule
